>>> hdl/hrlbm_pkg.sv
// ----------------------------------------------------------------------------
// hrlbm_pkg
// Shared constants for the hex register-list parser / burst merger.
// ----------------------------------------------------------------------------
package hrlbm_pkg;

  // characters the parser reacts to
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HI = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  // letter a..f / A..F low nibble plus this gives the digit value
  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  // register stride in bytes
  localparam logic [31:0] ADDR_STEP = 32'd4;

  // record kinds
  localparam logic KIND_SINGLE = 1'b0;
  localparam logic KIND_BURST  = 1'b1;

endpackage

>>> hdl/hex_register_list_burst_merger.sv
// ----------------------------------------------------------------------------
// hex_register_list_burst_merger
// Parses hex address/value text one byte per request and emits write records,
// merging runs of consecutive addresses into burst records.
// Output path: a held burst word goes S_DISP, S_BW, output register; a word
//   read from the run memory goes S_DISP, S_RD, S_WR, output register.
// Throughput: 1 byte/cycle while bytes only add digits or continue the run;
//   otherwise in_stall is held while the sequencer dispatches the pending run
//   operations, emits records read from memory and emits held burst words.
// Reset: synchronous, active low; clears parser, run and output state. The
//   run memory is not cleared; entries are read only after being written.
// ----------------------------------------------------------------------------
module hex_register_list_burst_merger
  import hrlbm_pkg::*;
#(
  parameter int BURST_MIN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // text byte requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  // write record requests
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_kind,
  output logic [31:0] out_write_address,
  output logic [31:0] out_write_data,
  output logic        out_burst_first,
  output logic        out_burst_last
);

  // words held in memory before a run turns into a burst
  localparam int HOLD_DEPTH = BURST_MIN - 1;
  localparam int LEN_W      = $clog2(BURST_MIN);
  localparam int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam logic [LEN_W-1:0] HOLD_LEN = LEN_W'(HOLD_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // taking text bytes
  localparam logic [2:0] S_DISP = 3'd1;  // pick next pending operation
  localparam logic [2:0] S_RD   = 3'd2;  // memory read in flight
  localparam logic [2:0] S_WR   = 3'd3;  // emit record from memory data
  localparam logic [2:0] S_BL   = 3'd4;  // emit held word as burst last
  localparam logic [2:0] S_BW   = 3'd5;  // emit held word, hold the new one

  // parser state
  logic [31:0]      acc_r, acc_nxt;
  logic             digits_r, digits_nxt;
  logic             comment_r, comment_nxt;
  logic             expect_r, expect_nxt;
  // run state
  logic [31:0]      run_start_r, run_start_nxt;
  logic [LEN_W-1:0] run_len_r, run_len_nxt;
  logic             burst_open_r, burst_open_nxt;
  logic [31:0]      held_addr_r, held_addr_nxt;
  logic [31:0]      held_val_r, held_val_nxt;
  // operations left over from the last accepted byte, done in this order
  logic             flush_a_r, flush_a_nxt;   // address broke the run
  logic [31:0]      start_val_r, start_val_nxt;
  logic             push_r, push_nxt;         // a value joins the run
  logic [31:0]      push_val_r, push_val_nxt;
  logic             end_r, end_nxt;           // end of text flush
  // sequencer
  logic [2:0]       state_r, state_nxt;
  logic             mode_burst_r, mode_burst_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]      emit_addr_r, emit_addr_nxt;
  // run memory
  logic [31:0]      run_mem [HOLD_DEPTH];
  logic [31:0]      rd_data_r;
  logic             mem_we;
  // output register
  logic             out_valid_r;
  logic             out_kind_r, out_first_r, out_last_r;
  logic [31:0]      out_addr_r, out_data_r;
  logic             out_load;
  logic             ld_kind, ld_first, ld_last;
  logic [31:0]      ld_addr, ld_data;
  logic             out_free;

  // byte classification
  logic             is_num, is_lower, is_upper, is_digit;
  logic [3:0]       digit_val;
  logic             tok_end, tok_addr, tok_val;
  logic [31:0]      acc_after;
  logic             expect_after;
  logic [31:0]      next_addr;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    is_num    = (in_text_byte inside {[CH_0:CH_9]});
    is_lower  = (in_text_byte inside {[CH_LA:CH_LF_HI]});
    is_upper  = (in_text_byte inside {[CH_UA:CH_UF]});
    is_digit  = !comment_r && (is_num || is_lower || is_upper);
    digit_val = is_num ? in_text_byte[3:0] : (in_text_byte[3:0] + HEX_LETTER_OFS);
    // any non-digit outside a comment ends a token that has digits
    tok_end   = !comment_r && !is_digit && digits_r;
    tok_addr  = tok_end && expect_r;
    tok_val   = tok_end && !expect_r;
    acc_after = tok_end ? '0 : (is_digit ? {acc_r[27:0], digit_val} : acc_r);
    expect_after = tok_end ? !expect_r : expect_r;
    // address that continues the current run
    next_addr = burst_open_r ? (held_addr_r + ADDR_STEP)
                             : (run_start_r + (32'(run_len_r) << 2));
  end

  always_comb begin
    acc_nxt        = acc_r;
    digits_nxt     = digits_r;
    comment_nxt    = comment_r;
    expect_nxt     = expect_r;
    run_start_nxt  = run_start_r;
    run_len_nxt    = run_len_r;
    burst_open_nxt = burst_open_r;
    held_addr_nxt  = held_addr_r;
    held_val_nxt   = held_val_r;
    flush_a_nxt    = flush_a_r;
    start_val_nxt  = start_val_r;
    push_nxt       = push_r;
    push_val_nxt   = push_val_r;
    end_nxt        = end_r;
    state_nxt      = state_r;
    mode_burst_nxt = mode_burst_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    emit_addr_nxt  = emit_addr_r;
    mem_we         = 1'b0;
    out_load       = 1'b0;
    ld_kind        = KIND_SINGLE;
    ld_addr        = emit_addr_r;
    ld_data        = rd_data_r;
    ld_first       = 1'b0;
    ld_last        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          acc_nxt    = acc_after;
          digits_nxt = tok_end ? 1'b0 : (digits_r || is_digit);
          expect_nxt = expect_after;
          if (comment_r) begin
            if (in_text_byte == CH_CR || in_text_byte == CH_LF) begin
              comment_nxt = 1'b0;
            end
          end else if (in_text_byte == CH_SLASH) begin
            comment_nxt = 1'b1;
          end
          flush_a_nxt   = tok_addr && (acc_r != next_addr);
          start_val_nxt = acc_r;
          // an address still waiting at end of text takes the accumulator
          push_nxt      = tok_val || (in_end_of_text && !expect_after);
          push_val_nxt  = tok_val ? acc_r : acc_after;
          end_nxt       = in_end_of_text;
          if (in_end_of_text) begin
            acc_nxt     = '0;
            digits_nxt  = 1'b0;
            comment_nxt = 1'b0;
            expect_nxt  = 1'b1;
          end
          if ((tok_addr && (acc_r != next_addr)) || tok_val || in_end_of_text) begin
            state_nxt = S_DISP;
          end
        end
      end

      S_DISP: begin
        if (flush_a_r || (!push_r && end_r)) begin
          // flush the run; the end-of-text flush leaves run start at zero
          flush_a_nxt    = 1'b0;
          if (!flush_a_r) begin
            end_nxt = 1'b0;
          end
          emit_addr_nxt  = run_start_r;
          run_start_nxt  = flush_a_r ? start_val_r : '0;
          run_len_nxt    = '0;
          cnt_nxt        = run_len_r;
          idx_nxt        = '0;
          mode_burst_nxt = 1'b0;
          if (burst_open_r) begin
            state_nxt = S_BL;
          end else if (run_len_r != '0) begin
            state_nxt = S_RD;
          end
        end else if (push_r) begin
          push_nxt = 1'b0;
          if (burst_open_r) begin
            state_nxt = S_BW;
          end else if (run_len_r < HOLD_LEN) begin
            mem_we      = 1'b1;
            run_len_nxt = run_len_r + LEN_W'(1);
          end else begin
            // run reached BURST_MIN: stored words leave as the burst head
            emit_addr_nxt  = run_start_r;
            cnt_nxt        = HOLD_LEN;
            idx_nxt        = '0;
            mode_burst_nxt = 1'b1;
            state_nxt      = S_RD;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_RD: begin
        state_nxt = S_WR;
      end

      S_WR: begin
        if (out_free) begin
          out_load      = 1'b1;
          ld_kind       = mode_burst_r ? KIND_BURST : KIND_SINGLE;
          ld_first      = mode_burst_r && (idx_r == '0);
          emit_addr_nxt = emit_addr_r + ADDR_STEP;
          if (LEN_W'(idx_r) == (cnt_r - LEN_W'(1))) begin
            if (mode_burst_r) begin
              held_addr_nxt  = emit_addr_r + ADDR_STEP;
              held_val_nxt   = push_val_r;
              burst_open_nxt = 1'b1;
              run_len_nxt    = '0;
            end
            state_nxt = S_DISP;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end

      S_BL: begin
        if (out_free) begin
          out_load       = 1'b1;
          ld_kind        = KIND_BURST;
          ld_addr        = held_addr_r;
          ld_data        = held_val_r;
          ld_last        = 1'b1;
          burst_open_nxt = 1'b0;
          state_nxt      = S_DISP;
        end
      end

      S_BW: begin
        if (out_free) begin
          out_load      = 1'b1;
          ld_kind       = KIND_BURST;
          ld_addr       = held_addr_r;
          ld_data       = held_val_r;
          held_addr_nxt = held_addr_r + ADDR_STEP;
          held_val_nxt  = push_val_r;
          state_nxt     = S_DISP;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      digits_r     <= 1'b0;
      comment_r    <= 1'b0;
      expect_r     <= 1'b1;
      run_start_r  <= '0;
      run_len_r    <= '0;
      burst_open_r <= 1'b0;
      flush_a_r    <= 1'b0;
      push_r       <= 1'b0;
      end_r        <= 1'b0;
      state_r      <= S_IDLE;
      mode_burst_r <= 1'b0;
      cnt_r        <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      acc_r        <= acc_nxt;
      digits_r     <= digits_nxt;
      comment_r    <= comment_nxt;
      expect_r     <= expect_nxt;
      run_start_r  <= run_start_nxt;
      run_len_r    <= run_len_nxt;
      burst_open_r <= burst_open_nxt;
      flush_a_r    <= flush_a_nxt;
      push_r       <= push_nxt;
      end_r        <= end_nxt;
      state_r      <= state_nxt;
      mode_burst_r <= mode_burst_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    held_addr_r <= held_addr_nxt;
    held_val_r  <= held_val_nxt;
    start_val_r <= start_val_nxt;
    push_val_r  <= push_val_nxt;
    emit_addr_r <= emit_addr_nxt;
    if (out_load) begin
      out_kind_r  <= ld_kind;
      out_addr_r  <= ld_addr;
      out_data_r  <= ld_data;
      out_first_r <= ld_first;
      out_last_r  <= ld_last;
    end
  end

  // run memory: writes only from dispatch, read data used only in S_WR, so the
  // sequencer itself keeps a write and a read of one entry apart
  always_ff @(posedge clk) begin
    if (mem_we) begin
      run_mem[run_len_r[IDX_W-1:0]] <= push_val_r;
    end
    rd_data_r <= run_mem[idx_r];
  end

  assign out_valid         = out_valid_r;
  assign out_record_kind   = out_kind_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;
  assign out_burst_first   = out_first_r;
  assign out_burst_last    = out_last_r;

endmodule

>>> hdl/hrlbm_checker.sv
// ----------------------------------------------------------------------------
// hrlbm_checker
// Port-level checks for the burst merger, bound to the top level.
// ----------------------------------------------------------------------------
module hrlbm_checker
  import hrlbm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_end_of_text,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_record_kind,
  input logic [31:0] out_write_address,
  input logic [31:0] out_write_data,
  input logic        out_burst_first,
  input logic        out_burst_last
);

  // a stalled record stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_write_address)
      && $stable(out_write_data) && $stable(out_record_kind))
    else $error("stalled record changed");

  // single writes carry no burst markers
  a_single_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_record_kind == KIND_SINGLE) |-> !out_burst_first && !out_burst_last)
    else $error("single record with burst marker");

  // a burst has at least two words
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_burst_first |-> !out_burst_last)
    else $error("burst first and last on one word");

  // end of text always starts a flush
  a_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_end_of_text |=> in_stall)
    else $error("end of text accepted without flush");

endmodule

bind hex_register_list_burst_merger hrlbm_checker u_hrlbm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_end_of_text    (in_end_of_text),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_record_kind   (out_record_kind),
  .out_write_address (out_write_address),
  .out_write_data    (out_write_data),
  .out_burst_first   (out_burst_first),
  .out_burst_last    (out_burst_last)
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb - hex register-list parser / burst merger
// Feeds hex address/value text one byte per request: short fixed texts
// first, then random register lists with runs, comments and noise. A local
// model of the parser predicts every write record, and the record stream is
// checked field by field against it. The sender and the receiver both idle
// at random, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb;
  import hrlbm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BURST_MIN   = 8;
  localparam int RUN_DEPTH   = BURST_MIN - 1;  // values held before a run turns into a burst
  localparam int TEXT_BYTES  = 410;
  localparam int HOLDOFF_AT  = 200;            // receiver cycle where the long hold-off starts
  localparam int HOLDOFF_LEN = 400;
  localparam int DRAIN_WAIT  = 60;

  typedef struct packed {
    logic [7:0] text;
    logic       eot;
  } text_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic        is_first;
    logic        is_last;
  } write_rec_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte   = 8'h00;
  logic        in_end_of_text = 1'b0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_record_kind;
  logic [31:0] out_write_address;
  logic [31:0] out_write_data;
  logic        out_burst_first;
  logic        out_burst_last;

  text_item_t  pending_q[$];        // bytes waiting to be offered
  write_rec_t  expected_writes[$];  // records the parser owes us, oldest first
  int          error_count = 0;

  always #1 clk = ~clk;

  hex_register_list_burst_merger #(
    .BURST_MIN(BURST_MIN)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_kind  (out_record_kind),
    .out_write_address(out_write_address),
    .out_write_data   (out_write_data),
    .out_burst_first  (out_burst_first),
    .out_burst_last   (out_burst_last)
  );

  // --------------------------------------------------------------------------
  // Parser model: token state, current run, open burst with its held word
  // --------------------------------------------------------------------------
  logic [31:0] hex_acc;
  logic        have_digits;
  logic        cmt_open;
  logic        want_addr;      // next token is an address
  logic [31:0] run_base;
  int          run_len;
  logic [31:0] run_vals [RUN_DEPTH];
  logic        burst_active;
  logic [31:0] hold_addr;      // newest burst word, kept back to tag it as last
  logic [31:0] hold_val;

  function automatic void expect_write(logic kind, logic [31:0] addr, logic [31:0] data,
                                       logic is_first, logic is_last);
    write_rec_t r;
    r.kind     = kind;
    r.addr     = addr;
    r.data     = data;
    r.is_first = is_first;
    r.is_last  = is_last;
    expected_writes.insert(expected_writes.size(), r);
  endfunction

  function automatic void clear_parser();
    hex_acc      = '0;
    have_digits  = 1'b0;
    cmt_open     = 1'b0;
    want_addr    = 1'b1;
    run_base     = '0;
    run_len      = 0;
    burst_active = 1'b0;
    hold_addr    = '0;
    hold_val     = '0;
  endfunction

  // A broken run: an open burst releases its held word as the last one,
  // a short run leaves as single writes.
  function automatic void close_run();
    if (burst_active) begin
      expect_write(KIND_BURST, hold_addr, hold_val, 1'b0, 1'b1);
      burst_active = 1'b0;
    end else begin
      for (int i = 0; i < run_len; i++)
        expect_write(KIND_SINGLE, run_base + ADDR_STEP * 32'(i), run_vals[i], 1'b0, 1'b0);
    end
    run_len = 0;
  endfunction

  function automatic void add_value(logic [31:0] v);
    if (burst_active) begin
      expect_write(KIND_BURST, hold_addr, hold_val, 1'b0, 1'b0);
      hold_addr = hold_addr + ADDR_STEP;
      hold_val  = v;
    end else if (run_len < RUN_DEPTH) begin
      run_vals[run_len] = v;
      run_len++;
    end else begin
      // run reaches the burst size: everything stored leaves, newest is held
      for (int i = 0; i < RUN_DEPTH; i++)
        expect_write(KIND_BURST, run_base + ADDR_STEP * 32'(i), run_vals[i],
                     (i == 0), 1'b0);
      hold_addr    = run_base + ADDR_STEP * 32'(RUN_DEPTH);
      hold_val     = v;
      burst_active = 1'b1;
      run_len      = 0;
    end
  endfunction

  function automatic void add_address(logic [31:0] a);
    logic [31:0] next_addr;
    next_addr = burst_active ? hold_addr + ADDR_STEP : run_base + ADDR_STEP * 32'(run_len);
    if (a != next_addr) begin
      close_run();
      run_base = a;
    end
  endfunction

  function automatic void finish_token();
    if (!have_digits)
      return;
    if (want_addr)
      add_address(hex_acc);
    else
      add_value(hex_acc);
    hex_acc     = '0;
    have_digits = 1'b0;
    want_addr   = !want_addr;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eot);
    int digit = -1;
    if (cmt_open) begin
      if (b == CH_CR || b == CH_LF)
        cmt_open = 1'b0;
    end else begin
      if (b >= CH_0 && b <= CH_9)
        digit = b - CH_0;
      else if (b >= CH_LA && b <= CH_LF_HI)
        digit = b - CH_LA + 10;
      else if (b >= CH_UA && b <= CH_UF)
        digit = b - CH_UA + 10;
      if (digit >= 0) begin
        hex_acc     = {hex_acc[27:0], 4'(digit)};
        have_digits = 1'b1;
      end else begin
        if (b == CH_SLASH)
          cmt_open = 1'b1;
        finish_token();
      end
    end
    // last byte: a value still owed takes the accumulator, then full flush
    if (eot) begin
      if (!want_addr)
        add_value(hex_acc);
      close_run();
      clear_parser();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Text generation
  // --------------------------------------------------------------------------
  task automatic push_byte(logic [7:0] b);
    text_item_t t;
    t.text = b;
    t.eot  = 1'b0;
    pending_q.insert(pending_q.size(), t);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i]);
  endtask

  task automatic mark_end();
    pending_q[pending_q.size() - 1].eot = 1'b1;
  endtask

  // Hex token in mixed case; sometimes leading zeros, sometimes a ninth
  // digit that the 32-bit accumulator shifts out again.
  task automatic push_hex(logic [31:0] v);
    string      s;
    logic [7:0] c;
    s = $sformatf("%0h", v);
    case ($urandom_range(0, 7))
      0: s = {"00", s};
      1: begin
        while (s.len() < 8)
          s = {"0", s};
        s = {$sformatf("%0h", $urandom_range(1, 15)), s};
      end
      default: ;
    endcase
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= CH_LA && c <= CH_LF_HI && $urandom_range(0, 1))
        c = c - 8'h20;
      push_byte(c);
    end
  endtask

  // Anything between tokens: blanks, line ends, odd bytes, comments.
  task automatic push_separator();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0, 1: push_byte(" ");
      2:    push_text("\r\n");
      3:    push_byte(8'($urandom_range(8'h80, 8'hff)));
      4:    push_text(", \t");
      5:    push_byte("g");
      6:    push_byte("\n");
      7: begin
        push_byte(CH_SLASH);
        repeat ($urandom_range(0, 6)) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
          push_byte(c);
        end
        push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'h0;
      2:       return 32'hffff_ffff;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic push_random_text();
    logic [31:0] base;
    int          pairs;
    if ($urandom_range(0, 9) == 0) begin
      // raw noise, any byte value
      repeat ($urandom_range(1, 16))
        push_byte(8'($urandom_range(0, 255)));
      mark_end();
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 4))
        0:       base = $urandom;
        1:       base = 32'hffff_fff0 + 32'($urandom_range(0, 3)) * ADDR_STEP;  // wraps past zero
        2:       base = $urandom_range(0, 31);                                 // misaligned too
        default: base = 32'($urandom_range(0, 63)) * ADDR_STEP;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: pairs = $urandom_range(1, 3);
        5, 6:          pairs = $urandom_range(RUN_DEPTH, BURST_MIN);
        default:       pairs = $urandom_range(BURST_MIN + 1, BURST_MIN + 5);
      endcase
      for (int k = 0; k < pairs; k++) begin
        push_hex(base + ADDR_STEP * 32'(k));
        push_separator();
        if ($urandom_range(0, 19) == 0)
          continue;  // drop a value: address/value order slips
        push_hex(pick_value());
        push_separator();
      end
    end
    case ($urandom_range(0, 4))
      1: push_hex($urandom_range(0, 255));  // unfinished address
      2: begin
        push_hex($urandom_range(0, 255));   // address without its value
        push_byte(" ");
      end
      3: begin
        push_hex($urandom_range(0, 255));   // ends on a value digit
        push_byte(" ");
        push_hex(pick_value());
      end
      4: push_text("/ab");                  // ends inside a comment
      default: ;
    endcase
    mark_end();
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of requests with random gaps; prediction at acceptance
  // --------------------------------------------------------------------------
  int         burst_left = 0;
  int         gap_left   = 0;
  text_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall)
        parse_byte(in_text_byte, in_end_of_text);
      if (in_valid && in_stall) begin
        // stalled: payload held as is
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        next_item       = pending_q.pop_front();
        in_valid       <= 1'b1;
        in_text_byte   <= next_item.text;
        in_end_of_text <= next_item.eot;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: windows of differing stall density, plus one long
  // hold-off while the sender keeps going, so the block backs up fully
  // --------------------------------------------------------------------------
  int          rx_cycle  = 0;
  int          mode_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_cycle  <= 0;
      mode_left <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(16, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (rx_cycle >= HOLDOFF_AT && rx_cycle < HOLDOFF_AT + HOLDOFF_LEN) begin
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:   out_stall <= 1'b0;
          STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          STALL_TOGGLE: out_stall <= !out_stall;
          default:      out_stall <= 1'b0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Record checker: every accepted record against the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      error_count++;
    end
  endfunction

  write_rec_t want_rec;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_writes.size() == 0) begin
        $error("unexpected record: addr %h data %h", out_write_address, out_write_data);
        error_count++;
      end else begin
        want_rec = expected_writes.pop_front();
        check_field("record_kind",   32'(want_rec.kind),     32'(out_record_kind));
        check_field("write_address", want_rec.addr,          out_write_address);
        check_field("write_data",    want_rec.data,          out_write_data);
        check_field("burst_first",   32'(want_rec.is_first), 32'(out_burst_first));
        check_field("burst_last",    32'(want_rec.is_last),  32'(out_burst_last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_parser();

    // Fixed texts. First one: address 0 continues the empty run, all-ones
    // value, comment with a slash inside closed by CR, repeated separators,
    // a misaligned address that breaks the run, and end of text on a value
    // digit. Then a lone address token that gets dropped, and an address
    // whose value never comes (flushed with zero).
    push_text("0 FFFFFFFF//a\r4 0  7,1");
    mark_end();
    push_text("5");
    mark_end();
    push_text("9 ");
    mark_end();

    while (pending_q.size() < TEXT_BYTES)
      push_random_text();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid)
      @(posedge clk);
    while (expected_writes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> hex_register_list_burst_merger.f
hdl/hrlbm_pkg.sv
hdl/hex_register_list_burst_merger.sv
hdl/hrlbm_checker.sv
bench/tb.sv
